### rtl/core/otsp_pkg.sv
// Package for the one-shot timer slot pool: sizes, codes, state and the
// store access structs. No dependencies.
`default_nettype none

package otsp_pkg;

    localparam int SLOTS    = 8;
    localparam int MAX_FIRE = 8;
    localparam int PTR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FIRE_W   = $clog2(MAX_FIRE + 1);
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 3;
    localparam int STATUS_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK  = 2'd0,
        FN_ALLOC = 2'd1,
        FN_DELAY = 2'd2,
        FN_KILL  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FIRED         = 3'd0,
        ST_ALLOCATED     = 3'd1,
        ST_NO_FREE       = 3'd2,
        ST_DELAY_DONE    = 3'd3,
        ST_DELAY_REFUSED = 3'd4,
        ST_KILLED_ACTIVE = 3'd5,
        ST_KILL_IDLE     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_OP,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic              set_timer;
        logic              set_ctx;
        logic              clr;
        logic [PTR_W-1:0]  addr;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] dur;
        logic [DATA_W-1:0] ctx;
    } store_wr_t;

    typedef struct packed {
        logic              active;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] dur;
        logic [DATA_W-1:0] ctx;
    } slot_rd_t;

endpackage

`default_nettype wire

### rtl/core/otsp_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on otsp_pkg.
`default_nettype none

interface otsp_req_if;
    logic                        valid;
    logic                        ready;
    logic [otsp_pkg::FUNC_W-1:0] func;
    logic [otsp_pkg::IDX_W-1:0]  slot_index;
    logic [otsp_pkg::DATA_W-1:0] wait_ticks;
    logic [otsp_pkg::DATA_W-1:0] user_context;

    modport source (output valid, func, slot_index, wait_ticks, user_context, input ready);
    modport sink   (input valid, func, slot_index, wait_ticks, user_context, output ready);
endinterface

interface otsp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [otsp_pkg::STATUS_W-1:0] status;
    logic [otsp_pkg::IDX_W-1:0]    result_slot;
    logic [otsp_pkg::DATA_W-1:0]   result_context;
    logic                          last;

    modport source (output valid, status, result_slot, result_context, last, input ready);
    modport sink   (input valid, status, result_slot, result_context, last, output ready);
endinterface

`default_nettype wire

### rtl/core/otsp_cmp.sv
// Shared expiry compare: wrapping elapsed time against the slot duration.
// Depends on otsp_pkg.
`default_nettype none

module otsp_cmp (
    input  wire logic [otsp_pkg::DATA_W-1:0] now,
    input  wire logic [otsp_pkg::DATA_W-1:0] start,
    input  wire logic [otsp_pkg::DATA_W-1:0] dur,
    output logic                             due
);
    import otsp_pkg::*;

    logic [DATA_W-1:0] elapsed;

    assign elapsed = now - start;
    assign due     = elapsed > dur;

endmodule

`default_nettype wire

### rtl/core/otsp_slot_store.sv
// Slot store: active bits plus start, duration and context per slot.
// Depends on otsp_pkg.
`default_nettype none

module otsp_slot_store (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire otsp_pkg::store_wr_t            wr,
    input  wire logic [otsp_pkg::PTR_W-1:0]     rd_addr,
    output otsp_pkg::slot_rd_t                  rd,
    input  wire logic [otsp_pkg::PTR_W-1:0]     q_addr,
    output logic                                q_active
);
    import otsp_pkg::*;

    logic [SLOTS-1:0]  active_reg;
    logic [DATA_W-1:0] start_mem [SLOTS];
    logic [DATA_W-1:0] dur_mem   [SLOTS];
    logic [DATA_W-1:0] ctx_mem   [SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (wr.set_timer)
        begin
            active_reg[wr.addr] <= 1'b1;
        end
        else if (wr.clr)
        begin
            active_reg[wr.addr] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.set_timer)
        begin
            start_mem[wr.addr] <= wr.start;
            dur_mem[wr.addr]   <= wr.dur;
        end
        if (wr.set_ctx)
        begin
            ctx_mem[wr.addr] <= wr.ctx;
        end
    end

    assign rd.active = active_reg[rd_addr];
    assign rd.start  = start_mem[rd_addr];
    assign rd.dur    = dur_mem[rd_addr];
    assign rd.ctx    = ctx_mem[rd_addr];
    assign q_active  = active_reg[q_addr];

endmodule

`default_nettype wire

### rtl/core/one_shot_timer_slot_pool_unit.sv
// One-shot timer slot pool: sequencer walking the slots through one shared compare.
// Tick: scan every slot, then flush the last fired word, if any; allocate: walk to
// the first free slot or the last, then flush; delay and kill: op, then flush. One
// word at a time. Walks take one slot per cycle; a scan holds on a blocked fired word.
// Reset clears the tick counter, all active bits and the control state at once.
// Depends on otsp_pkg, otsp_if, otsp_cmp and otsp_slot_store.
`default_nettype none

module one_shot_timer_slot_pool_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    otsp_req_if.sink  req,
    otsp_rsp_if.source rsp
);
    import otsp_pkg::*;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    func_t              func_reg, func_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [DATA_W-1:0]  dur_reg, dur_next;
    logic [DATA_W-1:0]  ctx_reg, ctx_next;
    logic [DATA_W-1:0]  tick_reg, tick_next;
    logic [FIRE_W-1:0]  fire_cnt_reg, fire_cnt_next;

    logic               pend_valid_reg, pend_valid_next;
    status_t            pend_status_reg, pend_status_next;
    logic [IDX_W-1:0]   pend_slot_reg, pend_slot_next;
    logic [DATA_W-1:0]  pend_ctx_reg, pend_ctx_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [IDX_W-1:0]   out_slot_reg, out_slot_next;
    logic [DATA_W-1:0]  out_ctx_reg, out_ctx_next;
    logic               out_last_reg, out_last_next;

    store_wr_t          wr;
    slot_rd_t           rd;
    logic               q_active;
    logic               due;
    logic               out_free;
    logic               fire;
    logic               at_last;
    logic               idx_ok;

    otsp_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_addr  (ptr_reg),
        .rd       (rd),
        .q_addr   (PTR_W'(idx_reg)),
        .q_active (q_active)
    );

    otsp_cmp u_cmp (
        .now   (tick_reg),
        .start (rd.start),
        .dur   (rd.dur),
        .due   (due)
    );

    assign out_free = !out_valid_reg || rsp.ready;
    assign at_last  = ptr_reg == PTR_W'(SLOTS - 1);
    assign idx_ok   = 32'(idx_reg) < 32'(SLOTS);
    assign fire     = rd.active && due && (fire_cnt_reg < FIRE_W'(MAX_FIRE));

    assign req.ready          = state_reg == S_IDLE;
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_slot    = out_slot_reg;
    assign rsp.result_context = out_ctx_reg;
    assign rsp.last           = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        func_next        = func_reg;
        idx_next         = idx_reg;
        dur_next         = dur_reg;
        ctx_next         = ctx_reg;
        tick_next        = tick_reg;
        fire_cnt_next    = fire_cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_ctx_next    = pend_ctx_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_ctx_next     = out_ctx_reg;
        out_last_next    = out_last_reg;
        wr               = '0;
        wr.start         = tick_reg;
        wr.dur           = dur_reg;
        wr.ctx           = ctx_reg;
        wr.addr          = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next     = func_t'(req.func);
                    idx_next      = req.slot_index;
                    dur_next      = req.wait_ticks;
                    ctx_next      = req.user_context;
                    ptr_next      = '0;
                    fire_cnt_next = '0;
                    case (func_t'(req.func))
                        FN_TICK:
                        begin
                            tick_next  = tick_reg + 32'd1;
                            state_next = S_SCAN;
                        end
                        FN_ALLOC: state_next = S_ALLOC;
                        default:  state_next = S_OP;
                    endcase
                end
            end

            S_SCAN:
            begin
                // a held fired word leaves only once a later one proves it is not last
                if (!(fire && pend_valid_reg && !out_free))
                begin
                    if (fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = pend_status_reg;
                            out_slot_next   = pend_slot_reg;
                            out_ctx_next    = pend_ctx_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_status_next = ST_FIRED;
                        pend_slot_next   = IDX_W'(ptr_reg);
                        pend_ctx_next    = rd.ctx;
                        fire_cnt_next    = fire_cnt_reg + FIRE_W'(1);
                        wr.clr           = 1'b1;
                    end
                    if (at_last)
                    begin
                        state_next = (pend_valid_reg || fire) ? S_FLUSH : S_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
            end

            S_ALLOC:
            begin
                if (!rd.active)
                begin
                    wr.set_timer     = 1'b1;
                    wr.set_ctx       = 1'b1;
                    pend_valid_next  = 1'b1;
                    pend_status_next = ST_ALLOCATED;
                    pend_slot_next   = IDX_W'(ptr_reg);
                    pend_ctx_next    = '0;
                    state_next       = S_FLUSH;
                end
                else if (at_last)
                begin
                    pend_valid_next  = 1'b1;
                    pend_status_next = ST_NO_FREE;
                    pend_slot_next   = '0;
                    pend_ctx_next    = '0;
                    state_next       = S_FLUSH;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end

            S_OP:
            begin
                wr.addr         = PTR_W'(idx_reg);
                pend_valid_next = 1'b1;
                pend_slot_next  = '0;
                pend_ctx_next   = '0;
                state_next      = S_FLUSH;
                if (func_reg == FN_DELAY)
                begin
                    if (idx_ok && q_active)
                    begin
                        wr.set_timer     = 1'b1;
                        pend_status_next = ST_DELAY_DONE;
                    end
                    else
                    begin
                        pend_status_next = ST_DELAY_REFUSED;
                    end
                end
                else
                begin
                    if (idx_ok && q_active)
                    begin
                        wr.clr           = 1'b1;
                        pend_status_next = ST_KILLED_ACTIVE;
                    end
                    else
                    begin
                        pend_status_next = ST_KILL_IDLE;
                    end
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_slot_next   = pend_slot_reg;
                    out_ctx_next    = pend_ctx_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        func_reg        <= func_next;
        idx_reg         <= idx_next;
        dur_reg         <= dur_next;
        ctx_reg         <= ctx_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_ctx_reg    <= pend_ctx_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_ctx_reg     <= out_ctx_next;
        out_last_reg    <= out_last_next;
    end

    a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_W'(MAX_FIRE))
        else $error("fire count beyond limit");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending word left behind in idle");

    a_flush_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |-> pend_valid_reg)
        else $error("flush with nothing pending");

    a_op_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && func_t'(req.func) != FN_TICK
        |=> state_reg == S_ALLOC || state_reg == S_OP)
        else $error("non-tick word not dispatched");

endmodule

`default_nettype wire
